// ===== hw/rtl/bndiv_pkg.sv =====
// Shared types and constants for the multi-limb divide-by-limb stream block.
// No dependencies; imported by the top level.
package bndiv_pkg;

    // Width of each stream field as it appears on the ports
    localparam int unsigned FIELD_W = 64;
    // Stream data width: two fields packed back to back
    localparam int unsigned TDATA_W = 2 * FIELD_W;

    // Sequencer states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } bndiv_state_t;

endpackage

// ===== hw/rtl/bignum_div_by_limb_stream.sv =====
// Top level of the multi-limb divide-by-single-limb stream block.
// Depends on bndiv_pkg and bndiv_unit.
//
// Divides an unsigned number, delivered one limb per request most significant
// limb first, by a single limb. The divisor is taken from the first request of
// each number and held until the request marked tlast. Each request yields one
// response carrying the quotient limb for the same position; the response to
// the last limb also carries the final remainder (zero otherwise) and tlast.
// A zero divisor is flagged on tuser with quotient and remainder forced to zero.
// Each limb runs through a shared radix-2 restoring divider that resolves one
// quotient bit per cycle, so a limb occupies the block from acceptance until
// its response is loaded into the output register (a zero divisor skips the
// divider); s_tready is low meanwhile. The response sits in an output register,
// so a stalled consumer does not hold off the next request; the response to
// that request then waits in the hold state until the output is free. Only the
// low LIMB_WIDTH bits of limb and divisor take part in the arithmetic.
module bignum_div_by_limb_stream
    import bndiv_pkg::*;
#(
    parameter int unsigned LIMB_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    // Request stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [63:0] limb, [127:64] divisor
    input  logic               s_tlast,   // last_limb
    // Response stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [63:0] quotient_limb, [127:64] remainder
    output logic               m_tlast,   // is_last
    output logic               m_tuser    // div_by_zero
);

    localparam int unsigned LW = LIMB_WIDTH;

    bndiv_state_t state_reg, state_next;

    logic [LW-1:0]      held_div_reg, held_div_next;
    logic [LW-1:0]      rem_reg, rem_next;
    logic               mid_reg, mid_next;
    logic               last_reg, last_next;
    logic               dz_reg, dz_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;
    logic               m_tuser_reg, m_tuser_next;

    logic               accept;
    logic [LW-1:0]      in_limb;
    logic [LW-1:0]      in_div;
    logic [LW-1:0]      cur_div;
    logic [LW-1:0]      cur_hi;
    logic               cur_dz;
    logic               out_free;
    logic               load;
    logic [LW-1:0]      q_res;
    logic [LW-1:0]      r_res;

    logic               div_start;
    logic               div_done;
    logic [LW-1:0]      div_quo;
    logic [LW-1:0]      div_rem;

    // Field extraction; bits above LIMB_WIDTH are ignored
    assign in_limb = s_tdata[LW-1:0];
    assign in_div  = s_tdata[FIELD_W +: LW];

    // The first limb of a number samples a fresh divisor and clears the remainder
    assign cur_div = mid_reg ? held_div_reg : in_div;
    assign cur_hi  = mid_reg ? rem_reg : '0;
    assign cur_dz  = (cur_div == '0);

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign div_start = accept && !cur_dz;

    assign out_free = !m_tvalid_reg || m_tready;

    // Zero divisor forces quotient and remainder to zero
    assign q_res = dz_reg ? '0 : div_quo;
    assign r_res = dz_reg ? '0 : div_rem;

    bndiv_unit #(
        .W (LW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .hi    (cur_hi),
        .lo    (in_limb),
        .d     (cur_div),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    always_comb
    begin
        state_next    = state_reg;
        held_div_next = held_div_reg;
        rem_next      = rem_reg;
        mid_next      = mid_reg;
        last_next     = last_reg;
        dz_next       = dz_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        load          = 1'b0;

        // Drop the response once the consumer takes it
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    held_div_next = cur_div;
                    mid_next      = !s_tlast;
                    last_next     = s_tlast;
                    dz_next       = cur_dz;
                    // Zero divisor skips the divider altogether
                    state_next    = cur_dz ? ST_HOLD : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (div_done)
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                // Divider outputs stay put until the next start
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {FIELD_W'(last_reg ? r_res : '0), FIELD_W'(q_res)};
            m_tlast_next  = last_reg;
            m_tuser_next  = dz_reg;
            // Carry the remainder into the next limb, clear it at end of number
            rem_next      = last_reg ? '0 : r_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            held_div_reg <= '0;
            rem_reg      <= '0;
            mid_reg      <= 1'b0;
            last_reg     <= 1'b0;
            dz_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_div_reg <= held_div_next;
            rem_reg      <= rem_next;
            mid_reg      <= mid_next;
            last_reg     <= last_next;
            dz_reg       <= dz_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Response payload needs no reset
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // The divider only finishes while the sequencer waits for it
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_RUN))
        else $error("divider finished outside the run state");

    // The carried remainder always stays below the held divisor
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_reg && (held_div_reg != '0)) |-> (rem_reg < held_div_reg))
        else $error("running remainder not below divisor");

    // A flagged zero divisor carries zero quotient and remainder
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tuser_reg) |-> (m_tdata_reg == '0))
        else $error("zero divisor response with nonzero data");

    // An accepted request always leaves the idle state
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after accepting a request");

endmodule

// ===== hw/rtl/bndiv_unit.sv =====
// Iterative radix-2 restoring divider: (hi : lo) / d, one quotient bit per cycle.
// Standalone; requires hi < d and d != 0. Instantiated by the top level.
module bndiv_unit #(
    parameter int unsigned W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] hi,
    input  logic [W-1:0] lo,
    input  logic [W-1:0] d,
    output logic         done,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem
);

    localparam int unsigned CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     r_reg;
    logic [W-1:0]     sh_reg;
    logic [W-1:0]     d_reg;

    logic             carry;
    logic [W-1:0]     r_shift;
    logic             take;
    logic [W-1:0]     r_next;
    logic [W-1:0]     sh_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        carry   = r_reg[W-1];
        r_shift = {r_reg[W-2:0], sh_reg[W-1]};
        take    = carry || (r_shift >= d_reg);
        r_next  = take ? (r_shift - d_reg) : r_shift;
        sh_next = {sh_reg[W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifter doubles as the quotient register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg  <= hi;
            sh_reg <= lo;
            d_reg  <= d;
        end
        else if (busy_reg)
        begin
            r_reg  <= r_next;
            sh_reg <= sh_next;
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;
    assign rem  = r_reg;

endmodule
